// ===== hw/rtl/fnv_hashed_position_table_core_macros.svh =====
// Assertion macros shared by the position table checker.
// Needs nothing but a clock named aclk and a reset named aresetn in scope.
`ifndef FNV_HASHED_POSITION_TABLE_CORE_MACROS_SVH
`define FNV_HASHED_POSITION_TABLE_CORE_MACROS_SVH

// Checked only outside reset
`define FNVPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define FNVPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/fnvpt_pkg.sv =====
// Types, constants and the FNV step function for the position table.
// No dependencies.
`timescale 1ns / 1ps

package fnvpt_pkg;

    localparam int TABLE_CAPACITY_DEF = 65536;
    localparam int INITIAL_SIZE_DEF   = 1024;
    localparam int PROBE_LIMIT_DEF    = 16;

    localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001B3;
    localparam int          FNV_PRIME_SHIFT = 40;

    localparam logic [31:0] EMPTY_TAG = 32'hFFFFFFFF;

    localparam logic [4:0] CAP_LOG2_RESET = 5'd16;
    localparam logic [4:0] CAP_LOG2_MIN   = 5'd4;
    localparam logic [4:0] CAP_LOG2_MAX   = 5'd20;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic CFG_IDX_CAPACITY = 1'b0;

    typedef struct packed {
        logic        action;
        logic [63:0] w3;
        logic [63:0] w2;
        logic [63:0] w1;
        logic [63:0] w0;
        logic [7:0]  ply;
        logic [31:0] tag;
    } qitem_t;

    typedef struct packed {
        logic       wr;
        logic [4:0] cap_log2;
    } cfg_cmd_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_HASH,
        FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_PROBE,
        BK_WRITE,
        BK_RESP,
        BK_COPY,
        BK_FILL
    } bk_state_t;

    // prime = 2^40 + 0x1B3, so the multiply is a shift plus a 64x9 product
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [63:0] w);
        logic [63:0] x;
        x = h ^ w;
        return (x << FNV_PRIME_SHIFT) + x * FNV_PRIME_LO;
    endfunction

endpackage

// ===== hw/rtl/fnv_hashed_position_table_core.sv =====
// Items are hashed in the front end, queued, then probed in the back end; the
// front end can take a new item while the back end still probes the last one.
// Probing uses the slot memory's one read port (one probe a cycle, up to 17
// probes for a lookup). Growth holds later items while it doubles the table.
// Reset and a capacity write clear all TABLE_CAPACITY+PROBE_LIMIT slots
// (65552 by default) in a clearing pass during which s_ready stays low.
`timescale 1ns / 1ps

module fnv_hashed_position_table_core #(
    parameter int TABLE_CAPACITY = fnvpt_pkg::TABLE_CAPACITY_DEF,
    parameter int INITIAL_SIZE   = fnvpt_pkg::INITIAL_SIZE_DEF,
    parameter int PROBE_LIMIT    = fnvpt_pkg::PROBE_LIMIT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [63:0] s_position_word0,
    input  logic [63:0] s_position_word1,
    input  logic [63:0] s_position_word2,
    input  logic [63:0] s_position_word3,
    input  logic [7:0]  s_ply_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fnvpt_pkg::*;

    logic [4:0] cap_reg;
    cfg_cmd_t   cfg;
    qitem_t     q_wdata, q_rdata;
    logic       q_wvalid, q_wready, q_rvalid, q_rready;
    logic       clearing;
    logic       cap_sel;

    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == CFG_IDX_CAPACITY);
    assign cfg.wr       = psel && penable && pwrite && cap_sel;
    assign cfg.cap_log2 = pwdata[4:0];
    assign prdata       = cap_sel ? {27'd0, cap_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_LOG2_RESET;
        end else if (cfg.wr) begin
            cap_reg <= pwdata[4:0];
        end
    end

    fnvpt_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_position_word0 (s_position_word0),
        .s_position_word1 (s_position_word1),
        .s_position_word2 (s_position_word2),
        .s_position_word3 (s_position_word3),
        .s_ply_count      (s_ply_count),
        .blocked          (clearing),
        .q_wdata          (q_wdata),
        .q_wvalid         (q_wvalid),
        .q_wready         (q_wready)
    );

    fnvpt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wdata   (q_wdata),
        .wvalid  (q_wvalid),
        .wready  (q_wready),
        .rdata   (q_rdata),
        .rvalid  (q_rvalid),
        .rready  (q_rready)
    );

    fnvpt_back #(
        .TABLE_CAPACITY (TABLE_CAPACITY),
        .INITIAL_SIZE   (INITIAL_SIZE),
        .PROBE_LIMIT    (PROBE_LIMIT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_rdata  (q_rdata),
        .q_rvalid (q_rvalid),
        .q_rready (q_rready),
        .clearing (clearing),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_found  (m_found)
    );

endmodule

// ===== hw/rtl/fnvpt_front.sv =====
// Front end: takes an item, runs the four FNV-1a rounds, folds the tag
// and pushes the classified item into the queue. Uses fnvpt_pkg.
`timescale 1ns / 1ps

module fnvpt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [63:0]         s_position_word0,
    input  logic [63:0]         s_position_word1,
    input  logic [63:0]         s_position_word2,
    input  logic [63:0]         s_position_word3,
    input  logic [7:0]          s_ply_count,
    input  logic                blocked,
    output fnvpt_pkg::qitem_t   q_wdata,
    output logic                q_wvalid,
    input  logic                q_wready
);
    import fnvpt_pkg::*;

    fe_state_t   state_reg, state_next;
    qitem_t      item_reg;
    logic [63:0] h_reg, h_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] word_sel;
    logic        take;

    always_comb begin
        unique case (step_reg)
            2'd0: word_sel = item_reg.w0;
            2'd1: word_sel = item_reg.w1;
            2'd2: word_sel = item_reg.w2;
            default: word_sel = item_reg.w3;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        h_next     = h_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        q_wvalid   = 1'b0;
        take       = 1'b0;
        q_wdata    = item_reg;
        q_wdata.tag = (h_reg[63:32] & h_reg[31:0]) ^ {24'd0, item_reg.ply};
        unique case (state_reg)
            FE_IDLE: begin
                s_ready = !blocked;
                if (s_valid && !blocked) begin
                    take       = 1'b1;
                    h_next     = FNV_BASIS;
                    step_next  = 2'd0;
                    state_next = FE_HASH;
                end
            end
            FE_HASH: begin
                h_next    = fnv_step(h_reg, word_sel);
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = FE_PUSH;
                end
            end
            default: begin
                q_wvalid = 1'b1;
                if (q_wready) begin
                    state_next = FE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg    <= h_next;
        step_reg <= step_next;
        if (take) begin
            item_reg.action <= s_action;
            item_reg.w0     <= s_position_word0;
            item_reg.w1     <= s_position_word1;
            item_reg.w2     <= s_position_word2;
            item_reg.w3     <= s_position_word3;
            item_reg.ply    <= s_ply_count;
            item_reg.tag    <= '0;
        end
    end

endmodule

// ===== hw/rtl/fnvpt_queue.sv =====
// Two-entry queue of hashed items between front and back end.
// Uses fnvpt_pkg.
`timescale 1ns / 1ps

module fnvpt_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  fnvpt_pkg::qitem_t wdata,
    input  logic              wvalid,
    output logic              wready,
    output fnvpt_pkg::qitem_t rdata,
    output logic              rvalid,
    input  logic              rready
);
    import fnvpt_pkg::*;

    qitem_t     slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wready = (cnt_reg != 2'd2);
    assign rvalid = (cnt_reg != 2'd0);
    assign rdata  = slot_reg[rptr_reg];
    assign push   = wvalid && wready;
    assign pop    = rready && rvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (push) wptr_reg <= !wptr_reg;
            if (pop)  rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/fnvpt_back.sv =====
// Back end: slot memory, probe sequencer, growth copy and clearing pass.
// Uses fnvpt_pkg; fed from fnvpt_queue.
`timescale 1ns / 1ps

module fnvpt_back #(
    parameter int TABLE_CAPACITY = fnvpt_pkg::TABLE_CAPACITY_DEF,
    parameter int INITIAL_SIZE   = fnvpt_pkg::INITIAL_SIZE_DEF,
    parameter int PROBE_LIMIT    = fnvpt_pkg::PROBE_LIMIT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fnvpt_pkg::cfg_cmd_t cfg,
    input  fnvpt_pkg::qitem_t   q_rdata,
    input  logic                q_rvalid,
    output logic                q_rready,
    output logic                clearing,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_found
);
    import fnvpt_pkg::*;

    localparam int CAP_LG  = $clog2(TABLE_CAPACITY);
    localparam int INIT_LG = $clog2(INITIAL_SIZE);
    localparam int SLOTS   = TABLE_CAPACITY + PROBE_LIMIT;
    localparam int AW      = $clog2(SLOTS);
    localparam int SW      = CAP_LG + 1;
    localparam int PW      = $clog2(PROBE_LIMIT + 2);
    localparam int EW      = 32 + 8 + 256;
    localparam logic [4:0]    CAP_LG5  = 5'(CAP_LG);
    localparam logic [4:0]    INIT_LG5 = 5'(INIT_LG);
    localparam logic [PW-1:0] N_INS    = PW'(PROBE_LIMIT);
    localparam logic [PW-1:0] N_LUP    = PW'(PROBE_LIMIT + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    logic [EW-1:0] mem [SLOTS];
    logic [EW-1:0] rd_data_reg, wr_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;

    bk_state_t     state_reg, state_next;
    logic [4:0]    cap_lg_reg, cap_lg_next;
    logic [4:0]    size_lg_reg, size_lg_next;
    logic [SW-1:0] tally_reg, tally_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] start_reg, start_next;
    logic [PW-1:0] iss_reg, iss_next;
    logic [PW-1:0] chk_reg, chk_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] slot_k_reg, slot_k_next;
    logic          found_reg, found_next;
    logic          grow_reg, grow_next;
    logic [SW-1:0] copy_reg, copy_next;
    logic          cpend_reg, cpend_next;
    logic [AW-1:0] cwaddr_reg, cwaddr_next;
    logic [PW-1:0] fill_reg, fill_next;
    logic          m_valid_reg, m_valid_next;
    logic          m_found_reg, m_found_next;

    logic [SW-1:0] size;
    logic [SW-1:0] mask;
    logic [PW-1:0] n_probe;
    logic [31:0]   rd_tag;
    logic [7:0]    rd_ply;
    logic [255:0]  rd_pos;
    logic          hit;
    logic [4:0]    cfg_lg;
    logic [SW-1:0] tally_inc;

    assign size    = SW'(1) << size_lg_reg;
    assign mask    = size - SW'(1);
    assign n_probe = (q_rdata.action == ACT_INSERT) ? N_INS : N_LUP;
    assign rd_tag  = rd_data_reg[EW-1 -: 32];
    assign rd_ply  = rd_data_reg[263:256];
    assign rd_pos  = rd_data_reg[255:0];
    assign tally_inc = tally_reg + SW'(1);

    always_comb begin
        if (q_rdata.action == ACT_INSERT) begin
            hit = (rd_tag == EMPTY_TAG);
        end else begin
            hit = (rd_tag == q_rdata.tag) && (rd_ply == q_rdata.ply) &&
                  (rd_pos == {q_rdata.w3, q_rdata.w2, q_rdata.w1, q_rdata.w0});
        end
    end

    // capacity value clamped to the supported range
    always_comb begin
        cfg_lg = cfg.cap_log2;
        if (cfg_lg < CAP_LOG2_MIN) cfg_lg = CAP_LOG2_MIN;
        if (cfg_lg > CAP_LOG2_MAX) cfg_lg = CAP_LOG2_MAX;
        if (cfg_lg > CAP_LG5)      cfg_lg = CAP_LG5;
    end

    always_comb begin
        state_next   = state_reg;
        cap_lg_next  = cap_lg_reg;
        size_lg_next = size_lg_reg;
        tally_next   = tally_reg;
        clr_next     = clr_reg;
        start_next   = start_reg;
        iss_next     = iss_reg;
        chk_next     = chk_reg;
        pend_next    = pend_reg;
        slot_k_next  = slot_k_reg;
        found_next   = found_reg;
        grow_next    = grow_reg;
        copy_next    = copy_reg;
        cpend_next   = cpend_reg;
        cwaddr_next  = cwaddr_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_found_next = m_found_reg;
        rd_addr      = start_reg;
        wr_en        = 1'b0;
        wr_addr      = clr_reg;
        wr_data      = {EMPTY_TAG, 264'd0};
        q_rready     = 1'b0;

        unique case (state_reg)
            BK_CLEAR: begin
                wr_en    = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_SLOT) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_rvalid) begin
                    start_next = AW'(q_rdata.tag[CAP_LG-1:0] & mask[CAP_LG-1:0]);
                    iss_next   = '0;
                    chk_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    grow_next  = 1'b0;
                    state_next = BK_PROBE;
                end
            end
            BK_PROBE: begin
                // reads issue one per cycle; each is checked in the next cycle
                if (iss_reg < n_probe) begin
                    rd_addr   = start_reg + AW'(iss_reg);
                    iss_next  = iss_reg + PW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (hit || chk_reg == n_probe - PW'(1)) begin
                        slot_k_next = hit ? chk_reg : N_INS;
                        found_next  = hit && (q_rdata.action == ACT_LOOKUP);
                        state_next  = (q_rdata.action == ACT_INSERT) ? BK_WRITE : BK_RESP;
                    end else begin
                        chk_next = chk_reg + PW'(1);
                    end
                end
            end
            BK_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = start_reg + AW'(slot_k_reg);
                wr_data = {q_rdata.tag, q_rdata.ply,
                           q_rdata.w3, q_rdata.w2, q_rdata.w1, q_rdata.w0};
                if (size_lg_reg < cap_lg_reg) begin
                    tally_next = tally_inc;
                    grow_next  = (tally_inc >= size);
                end
                state_next = BK_RESP;
            end
            BK_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    q_rready     = 1'b1;
                    copy_next    = '0;
                    cpend_next   = 1'b0;
                    state_next   = grow_reg ? BK_COPY : BK_IDLE;
                end
            end
            BK_COPY: begin
                // lower half goes to the upper half, one slot per cycle
                if (copy_reg < size) begin
                    rd_addr     = AW'(copy_reg);
                    copy_next   = copy_reg + SW'(1);
                    cpend_next  = 1'b1;
                    cwaddr_next = AW'(size) + AW'(copy_reg);
                end else begin
                    cpend_next = 1'b0;
                end
                if (cpend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = cwaddr_reg;
                    wr_data = rd_data_reg;
                end
                if (copy_reg == size && !cpend_reg) begin
                    size_lg_next = size_lg_reg + 5'd1;
                    fill_next    = '0;
                    state_next   = BK_FILL;
                end
            end
            default: begin
                // overflow slots above the new size become empty
                wr_en     = 1'b1;
                wr_addr   = AW'(size) + AW'(fill_reg);
                fill_next = fill_reg + PW'(1);
                if (fill_reg == PW'(PROBE_LIMIT - 1)) begin
                    state_next = BK_IDLE;
                end
            end
        endcase

        if (cfg.wr) begin
            cap_lg_next  = cfg_lg;
            size_lg_next = (INIT_LG5 < cfg_lg) ? INIT_LG5 : cfg_lg;
            tally_next   = '0;
            clr_next     = '0;
            state_next   = BK_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_CLEAR;
            cap_lg_reg  <= (CAP_LOG2_RESET > CAP_LG5) ? CAP_LG5 : CAP_LOG2_RESET;
            size_lg_reg <= (INIT_LG5 < CAP_LOG2_RESET && INIT_LG5 < CAP_LG5) ? INIT_LG5 :
                           ((CAP_LOG2_RESET > CAP_LG5) ? CAP_LG5 : CAP_LOG2_RESET);
            tally_reg   <= '0;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            cpend_reg   <= 1'b0;
            grow_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_lg_reg  <= cap_lg_next;
            size_lg_reg <= size_lg_next;
            tally_reg   <= tally_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            cpend_reg   <= cpend_next;
            grow_reg    <= grow_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg   <= start_next;
        iss_reg     <= iss_next;
        chk_reg     <= chk_next;
        slot_k_reg  <= slot_k_next;
        found_reg   <= found_next;
        copy_reg    <= copy_next;
        cwaddr_reg  <= cwaddr_next;
        fill_reg    <= fill_next;
        m_found_reg <= m_found_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign clearing = (state_reg == BK_CLEAR);
    assign m_valid  = m_valid_reg;
    assign m_found  = m_found_reg;

endmodule

// ===== hw/rtl/fnvpt_checker.sv =====
// Port-level checks for the position table, bound to the top level.
// Needs fnv_hashed_position_table_core_macros.svh.
`timescale 1ns / 1ps

module fnvpt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_found,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);
`include "fnv_hashed_position_table_core_macros.svh"

    // held result
    `FNVPT_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_found), "result item changed while stalled")

    // reset drops the result and starts the clearing pass
    `FNVPT_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid && !s_ready, "not quiet after reset")

    // capacity register reads back what was written
    `FNVPT_ASSERT(a_cap_readback, psel && penable && pwrite && !paddr[2] |=> prdata[4:0] == $past(pwdata[4:0]), "capacity readback mismatch")

    `FNVPT_ASSERT(a_pready, pready, "pready low")

endmodule

bind fnv_hashed_position_table_core fnvpt_checker u_fnvpt_checker (.*);

// ===== test/tb_fnv_hashed_position_table_core.sv =====
// Self-checking testbench for fnv_hashed_position_table_core: inserts and lookups of
// packed positions, checked against a behavioral copy of the hashed table.
// Depends on fnvpt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_fnv_hashed_position_table_core;
    import fnvpt_pkg::*;

    localparam int  SLOTS     = TABLE_CAPACITY_DEF + PROBE_LIMIT_DEF;
    localparam int  PROBES    = PROBE_LIMIT_DEF;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001B3;
    localparam logic [2:0]  ADDR_CAPACITY = 3'd0;
    localparam logic [2:0]  ADDR_UNUSED   = 3'd4;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  GROW_SETTLE = 2300;

    typedef struct {
        logic        action;
        logic [63:0] w [4];
        logic [7:0]  ply;
    } pos_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = 1'b0;
    logic [63:0] s_position_word0 = '0;
    logic [63:0] s_position_word1 = '0;
    logic [63:0] s_position_word2 = '0;
    logic [63:0] s_position_word3 = '0;
    logic [7:0]  s_ply_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fnv_hashed_position_table_core DUT (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // behavioral table state
    logic [31:0] tag_mem [SLOTS];
    logic [7:0]  ply_mem [SLOTS];
    logic [63:0] pos_mem [SLOTS][4];
    int unsigned live_size;
    int unsigned insert_count;
    logic [4:0]  cap_reg;

    pos_item_t   pend_q[$];
    logic        found_q[$];
    pos_item_t   key_pool[$];
    pos_item_t   cur_item;
    logic        in_took = 1'b0;
    int          fail_cnt = 0;
    int unsigned cyc = 0;

    function automatic int unsigned table_cap(input logic [4:0] l2);
        int unsigned l;
        l = (l2 < CAP_LOG2_MIN) ? CAP_LOG2_MIN : (l2 > CAP_LOG2_MAX) ? CAP_LOG2_MAX : l2;
        return ((1 << l) > TABLE_CAPACITY_DEF) ? TABLE_CAPACITY_DEF : (1 << l);
    endfunction

    function automatic void clear_table();
        int unsigned cap;
        cap = table_cap(cap_reg);
        live_size = (INITIAL_SIZE_DEF < cap) ? INITIAL_SIZE_DEF : cap;
        insert_count = 0;
        for (int k = 0; k < SLOTS; k++) begin
            tag_mem[k] = EMPTY_TAG;
            ply_mem[k] = '0;
            for (int j = 0; j < 4; j++) pos_mem[k][j] = '0;
        end
    endfunction

    function automatic logic [31:0] position_tag(input pos_item_t it);
        logic [63:0] h;
        h = FNV_BASIS;
        for (int k = 0; k < 4; k++) h = (h ^ it.w[k]) * HASH_PRIME;
        return (h[63:32] & h[31:0]) ^ {24'd0, it.ply};
    endfunction

    function automatic logic apply_item(input pos_item_t it);
        logic [31:0] tag;
        int unsigned idx, sz;
        logic hit;
        tag = position_tag(it);
        idx = tag & (live_size - 1);
        hit = 1'b0;
        if (it.action == ACT_INSERT) begin
            for (int k = 0; k < PROBES; k++) begin
                if (tag_mem[idx] == EMPTY_TAG) break;
                idx++;
            end
            tag_mem[idx] = tag;
            ply_mem[idx] = it.ply;
            for (int j = 0; j < 4; j++) pos_mem[idx][j] = it.w[j];
            if (live_size < table_cap(cap_reg)) begin
                insert_count++;
                if (insert_count >= live_size && 2 * live_size + PROBES <= SLOTS) begin
                    sz = live_size;
                    for (int k = 0; k < sz; k++) begin
                        tag_mem[sz + k] = tag_mem[k];
                        ply_mem[sz + k] = ply_mem[k];
                        for (int j = 0; j < 4; j++) pos_mem[sz + k][j] = pos_mem[k][j];
                    end
                    live_size = 2 * sz;
                    for (int k = 0; k < PROBES; k++) tag_mem[live_size + k] = EMPTY_TAG;
                end
            end
        end else begin
            for (int k = 0; k <= PROBES; k++) begin
                if (idx >= SLOTS) break;
                if (tag_mem[idx] == tag && ply_mem[idx] == it.ply &&
                    pos_mem[idx][0] == it.w[0] && pos_mem[idx][1] == it.w[1] &&
                    pos_mem[idx][2] == it.w[2] && pos_mem[idx][3] == it.w[3]) begin
                    hit = 1'b1;
                    break;
                end
                idx++;
            end
        end
        return hit;
    endfunction

    // a tag equal to the empty marker would make a lookup read unwritten slots
    task automatic queue_item(input pos_item_t it);
        if (position_tag(it) == EMPTY_TAG) begin
            it.ply = it.ply ^ 8'h01;
        end
        if (it.action == ACT_INSERT) key_pool.push_back(it);
        pend_q.push_back(it);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_random(input int lookup_pct);
        pos_item_t it;
        int pick;
        it.action = ($urandom_range(99) < lookup_pct) ? ACT_LOOKUP : ACT_INSERT;
        if (key_pool.size() > 0 && $urandom_range(99) < 70) begin
            pick = $urandom_range(key_pool.size() - 1);
            it.w = key_pool[pick].w;
            it.ply = key_pool[pick].ply;
            // near misses: flip one glyph bit or add one to the ply
            case ($urandom_range(9))
                0: it.w[$urandom_range(3)][$urandom_range(63)] ^= 1'b1;
                1: it.ply = it.ply + 8'd1;
                default: ;
            endcase
        end else begin
            for (int j = 0; j < 4; j++) it.w[j] = rand_word();
            it.ply = 8'($urandom_range(255));
        end
        queue_item(it);
    endtask

    task automatic queue_directed();
        pos_item_t it;
        for (int n = 0; n < 8; n++) begin
            it.action = n[0] ? ACT_LOOKUP : ACT_INSERT;
            for (int j = 0; j < 4; j++) it.w[j] = n[1] ? '1 : '0;
            it.ply = n[2] ? 8'hFF : 8'h00;
            queue_item(it);
        end
        // absent key, then insert it and look it up, other ply, one bit flipped
        it.w[0] = 64'h0123456789ABCDEF; it.w[1] = 64'hFEDCBA9876543210;
        it.w[2] = 64'h5555AAAA5555AAAA; it.w[3] = 64'hAAAA5555AAAA5555;
        it.ply = 8'd40;
        it.action = ACT_LOOKUP; queue_item(it);
        it.action = ACT_INSERT; queue_item(it);
        it.action = ACT_LOOKUP; queue_item(it);
        it.ply = 8'd41;         queue_item(it);
        it.w[3][63] = 1'b0; it.ply = 8'd40; queue_item(it);
        // same key inserted twice, then looked up
        it.action = ACT_INSERT; queue_item(it); queue_item(it);
        it.action = ACT_LOOKUP; queue_item(it);
    endtask

    task automatic wait_drained();
        wait (pend_q.size() == 0 && found_q.size() == 0 && !s_valid);
        repeat (GROW_SETTLE) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == ADDR_CAPACITY) begin
            cap_reg = data[4:0];
            clear_table();
            key_pool.delete();
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic run_phase(input logic [2:0] addr, input logic [4:0] l2,
                             input int count, input int lookup_pct);
        wait_drained();
        apb_write(addr, {27'd0, l2});
        for (int n = 0; n < count; n++) queue_random(lookup_pct);
    endtask

    function automatic logic idle_roll();
        if (cyc % 5000 < 1500) return 1'b0;
        return $urandom_range(99) < 12;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_took) begin
                if (pend_q.size() > 0 && !idle_roll()) begin
                    cur_item = pend_q.pop_front();
                    s_valid <= 1'b1;
                    s_action <= cur_item.action;
                    s_position_word0 <= cur_item.w[0];
                    s_position_word1 <= cur_item.w[1];
                    s_position_word2 <= cur_item.w[2];
                    s_position_word3 <= cur_item.w[3];
                    s_ply_count <= cur_item.ply;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !idle_roll();
        end
    end

    // accept, predict, check
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        in_took <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) found_q.push_back(apply_item(cur_item));
        if (aresetn && m_valid && m_ready) begin
            if (found_q.size() == 0) begin
                $error("found: result with none expected (actual %0b)", m_found);
                fail_cnt++;
            end else begin
                logic exp_found;
                exp_found = found_q.pop_front();
                if (m_found !== exp_found) begin
                    $error("found: expected %0b actual %0b", exp_found, m_found);
                    fail_cnt++;
                end
            end
        end
        if (cyc > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        cap_reg = CAP_LOG2_RESET;
        clear_table();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        queue_directed();
        for (int n = 0; n < 160; n++) queue_random(45);
        run_phase(ADDR_CAPACITY, 5'd4, 120, 45);   // tiny table: full, overwrite path
        run_phase(ADDR_CAPACITY, 5'd0, 40, 50);    // clamps up to the minimum
        run_phase(ADDR_CAPACITY, 5'd31, 60, 45);   // clamps down to the maximum
        run_phase(ADDR_UNUSED, 5'd4, 30, 45);      // unmapped address, no effect
        run_phase(ADDR_CAPACITY, 5'd11, 124, 30);  // mid-size table, mostly inserts
        wait (pend_q.size() == 0 && found_q.size() == 0 && !s_valid);
        repeat (100) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
